### hdl/sfef_pkg.sv
`default_nettype none

package sfef_pkg;

    // Node index width is fixed by the edge format; the parent table covers every index.
    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int WEIGHT_W  = 32;

    // Stream payload widths, padded to whole bytes
    localparam int FIELDS_W  = 2 * NODE_W + WEIGHT_W;
    localparam int DATA_W    = ((FIELDS_W + 7) / 8) * 8;

    // Last node index, where the clearing pass stops
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

    typedef logic [NODE_W-1:0] node_t;

    // Union-find sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_LINK
    } uf_state_t;

    // Top level to engine
    typedef struct packed {
        logic  start;       // edge accepted this cycle
        node_t first_node;
        node_t second_node;
        logic  res_ready;   // output register can take a result
    } uf_cmd_t;

    // Engine to top level
    typedef struct packed {
        logic  idle;        // ready for a new edge
        logic  done;        // result valid this cycle
        logic  joined;
        node_t first_node;
        node_t second_node;
    } uf_sts_t;

endpackage

`default_nettype wire

### hdl/sfef_uf_engine.sv
`default_nettype none

module sfef_uf_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sfef_pkg::uf_cmd_t cmd,
    output sfef_pkg::uf_sts_t      sts
);
    import sfef_pkg::*;

    uf_state_t state_reg, state_next;
    node_t     clr_reg, clr_next;
    node_t     cur_reg, cur_next;
    node_t     root_reg, root_next;
    node_t     ru_reg, ru_next;
    logic      side_reg, side_next;
    node_t     u_reg, v_reg;

    // Parent table, one write and one registered read per cycle
    node_t     parent_mem [MAX_NODES];
    node_t     rd_data_reg;
    node_t     rd_addr;
    logic      wr_en;
    node_t     wr_addr;
    node_t     wr_data;
    node_t     start_node;

    // Write-first memory: a read of the address being written returns the new value
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= parent_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cur_reg   <= '0;
            root_reg  <= '0;
            ru_reg    <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cur_reg   <= cur_next;
            root_reg  <= root_next;
            ru_reg    <= ru_next;
            side_reg  <= side_next;
        end
    end

    // Edge endpoints, held for the whole edge
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            u_reg <= cmd.first_node;
            v_reg <= cmd.second_node;
        end
    end

    assign start_node = side_reg ? v_reg : u_reg;

    // Sequencer: clear table; find root, compress path, per endpoint; then link
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        ru_next         = ru_reg;
        side_next       = side_reg;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = root_reg;
        sts.idle        = 1'b0;
        sts.done        = 1'b0;
        sts.joined      = 1'b0;
        sts.first_node  = u_reg;
        sts.second_node = v_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // every node starts as its own root
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                sts.idle = 1'b1;
                rd_addr  = cmd.first_node;
                if (cmd.start)
                begin
                    cur_next   = cmd.first_node;
                    side_next  = 1'b0;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                // rd_data_reg holds parent of cur_reg
                if (rd_data_reg == cur_reg)
                begin
                    root_next  = cur_reg;
                    rd_addr    = start_node;
                    cur_next   = start_node;
                    state_next = ST_COMP;
                end
                else
                begin
                    rd_addr  = rd_data_reg;
                    cur_next = rd_data_reg;
                end
            end
            ST_COMP:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!side_reg)
                    begin
                        ru_next    = root_reg;
                        side_next  = 1'b1;
                        rd_addr    = v_reg;
                        cur_next   = v_reg;
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    // point this node at the root, move on to its old parent
                    wr_en    = 1'b1;
                    rd_addr  = rd_data_reg;
                    cur_next = rd_data_reg;
                end
            end
            ST_LINK:
            begin
                if (cmd.res_ready)
                begin
                    sts.done   = 1'b1;
                    sts.joined = (ru_reg != root_reg);
                    wr_en      = (ru_reg != root_reg);
                    wr_addr    = root_reg;
                    wr_data    = ru_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == ST_IDLE)
        else $error("edge started while engine busy");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> cmd.res_ready)
        else $error("result issued while output register full");

    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_reg == LAST_NODE) |=> state_reg == ST_IDLE)
        else $error("clearing pass did not finish");

    a_joined_link: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.done && sts.joined) |-> (wr_en && wr_addr == root_reg && wr_data == ru_reg))
        else $error("joined edge without link write");

    a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND || state_reg == ST_IDLE) |-> !wr_en)
        else $error("parent table written outside compress or link");
`endif

endmodule

`default_nettype wire

### hdl/spanning_forest_edge_filter_core.sv
`default_nettype none

// Union-find filter for Kruskal's spanning forest. Feed edges in ascending weight
// order; each edge returns one result saying whether it joined two components
// (m_tuser = 1) or closed a cycle (m_tuser = 0), with endpoints and weight echoed.
// After reset the parent table is initialized one entry per cycle, so s_tready
// stays low until all 1024 entries are written. The work for an edge grows with
// du and dv, the path lengths from each endpoint to its root: every step is one
// access to the single parent-table memory, first walking to the root, then
// walking again to rewrite the path. With path compression most paths are zero
// to two hops. The engine returns to idle as the result is registered, and then
// takes the next edge. One edge is in work at a time; a finished result waits in
// the output register while the next edge is taken.
module spanning_forest_edge_filter_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // first_node[9:0], second_node[19:10], edge_weight[51:20], zero pad
    input  wire logic [sfef_pkg::DATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // end_one[9:0], end_two[19:10], weight_out[51:20], zero pad
    output logic [sfef_pkg::DATA_W-1:0]      m_tdata,
    // joined
    output logic                             m_tuser
);
    import sfef_pkg::*;

    uf_cmd_t cmd;
    uf_sts_t sts;

    logic                s_accept;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                out_valid_reg;
    logic                out_joined_reg;
    logic [DATA_W-1:0]   out_data_reg;

    // Input transaction
    assign s_tready = sts.idle;
    assign s_accept = s_tvalid && s_tready;

    assign cmd.start       = s_accept;
    assign cmd.first_node  = s_tdata[NODE_W-1:0];
    assign cmd.second_node = s_tdata[2*NODE_W-1:NODE_W];
    assign cmd.res_ready   = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            weight_reg <= s_tdata[FIELDS_W-1:2*NODE_W];
        end
    end

    sfef_uf_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sts.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sts.done)
        begin
            out_joined_reg <= sts.joined;
            out_data_reg   <= DATA_W'({weight_reg, sts.second_node, sts.first_node});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_joined_reg;

endmodule

`default_nettype wire

### dv/forest_verdict_checker.sv
`default_nettype none

module forest_verdict_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [sfef_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [sfef_pkg::DATA_W-1:0] m_tdata,
    input  wire logic                        m_tuser,
    output int                               fail_count,
    output int                               pending,
    output int                               checked,
    output int                               joins
);

    timeunit 1ns;
    timeprecision 1ps;

    import sfef_pkg::*;

    typedef struct packed {
        logic                joined;
        node_t               end_one;
        node_t               end_two;
        logic [WEIGHT_W-1:0] weight_out;
    } edge_verdict_t;

    // Own copy of the union-find forest
    node_t         forest_parent [MAX_NODES];
    edge_verdict_t verdict_q [$];
    int            mismatches = 0;
    int            seen       = 0;
    int            joined_cnt = 0;

    // Walk to the root, then point every node on the walked path straight at it
    function automatic node_t root_and_flatten(node_t start);
        node_t root;
        node_t cur;
        node_t nxt;
        int    steps;
        root  = start;
        steps = 0;
        while (forest_parent[root] != root && steps < MAX_NODES)
        begin
            root = forest_parent[root];
            steps++;
        end
        cur   = start;
        steps = 0;
        while (cur != root && steps < MAX_NODES)
        begin
            nxt                = forest_parent[cur];
            forest_parent[cur] = root;
            cur                = nxt;
            steps++;
        end
        return root;
    endfunction

    // Every 10-bit index is inside the table, so no range rejection arises here
    function automatic edge_verdict_t judge_edge(logic [DATA_W-1:0] item);
        edge_verdict_t v;
        node_t         ru;
        node_t         rv;
        v.end_one    = item[NODE_W-1:0];
        v.end_two    = item[2*NODE_W-1:NODE_W];
        v.weight_out = item[2*NODE_W +: WEIGHT_W];
        v.joined     = 1'b0;
        ru = root_and_flatten(v.end_one);
        rv = root_and_flatten(v.end_two);
        if (ru != rv)
        begin
            forest_parent[rv] = ru;
            v.joined          = 1'b1;
        end
        return v;
    endfunction

    // Result side is compared before the input side is predicted: an edge
    // accepted at this edge cannot have its result out at the same edge
    always @(posedge clk)
    begin
        edge_verdict_t exp_v;
        edge_verdict_t act_v;
        edge_verdict_t new_v;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
                forest_parent[i] = node_t'(i);
            verdict_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                act_v.joined     = m_tuser;
                act_v.end_one    = m_tdata[NODE_W-1:0];
                act_v.end_two    = m_tdata[2*NODE_W-1:NODE_W];
                act_v.weight_out = m_tdata[2*NODE_W +: WEIGHT_W];
                if (verdict_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: %p", act_v);
                    mismatches++;
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    seen++;
                    if (exp_v.joined)
                        joined_cnt++;
                    if (act_v.joined !== exp_v.joined)
                    begin
                        $error("joined: expected %0d, got %0d", exp_v.joined, act_v.joined);
                        mismatches++;
                    end
                    if (act_v.end_one !== exp_v.end_one)
                    begin
                        $error("end_one: expected %0d, got %0d",
                               exp_v.end_one, act_v.end_one);
                        mismatches++;
                    end
                    if (act_v.end_two !== exp_v.end_two)
                    begin
                        $error("end_two: expected %0d, got %0d",
                               exp_v.end_two, act_v.end_two);
                        mismatches++;
                    end
                    if (act_v.weight_out !== exp_v.weight_out)
                    begin
                        $error("weight_out: expected %0d, got %0d",
                               $signed(exp_v.weight_out), $signed(act_v.weight_out));
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                new_v = judge_edge(s_tdata);
                verdict_q.insert(verdict_q.size(), new_v);
            end
        end
        fail_count <= mismatches;
        pending    <= verdict_q.size();
        checked    <= seen;
        joins      <= joined_cnt;
    end

endmodule

`default_nettype wire

### dv/spanning_forest_edge_filter_core_test.sv
`default_nettype none

module spanning_forest_edge_filter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sfef_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;

    int fail_count;
    int pending;
    int checked;
    int joins;
    int edges_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_len;

    spanning_forest_edge_filter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    forest_verdict_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .joins      (joins)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop; sized for deep chains, stalls and the clearing pass
    initial
    begin
        #20_000_000;
        $display("spanning_forest_edge_filter_core: mismatch");
        $finish;
    end

    // Result side backpressure; a requested long hold-off is counted here
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One edge transaction, with a random idle gap in front of it
    task automatic send_edge(node_t a, node_t b, logic [WEIGHT_W-1:0] w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({w, b, a});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        edges_sent++;
    endtask

    // Stop offering edges until every result is back, with a cycle limit
    task automatic wait_drained(int limit);
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while ((pending != 0 || s_tvalid) && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Random graphs: long parent chains, small clusters with ascending weights, noise
    task automatic run_graphs(int n_items);
        int                  sent;
        int                  kind;
        int                  span;
        int                  len;
        node_t               base;
        node_t               a;
        node_t               b;
        logic [WEIGHT_W-1:0] w;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            base = node_t'($urandom);
            w    = $urandom;
            if (kind < 15)
            begin
                // chain, then one edge from its tail walks the whole path
                len = $urandom_range(4, 40);
                for (int i = 0; i < len && sent < n_items; i++)
                begin
                    send_edge(base + node_t'(i + 1), base + node_t'(i), w);
                    w += $urandom_range(0, 50);
                    sent++;
                end
                send_edge(base, base + node_t'(len + 1), w);
                sent++;
            end
            else if (kind < 85)
            begin
                span = ($urandom_range(9) == 0) ? MAX_NODES : $urandom_range(2, 32);
                len  = $urandom_range(4, 30);
                for (int i = 0; i < len && sent < n_items; i++)
                begin
                    a = base + node_t'($urandom_range(span - 1));
                    b = base + node_t'($urandom_range(span - 1));
                    send_edge(a, b, w);
                    w += $urandom_range(0, 1000);
                    sent++;
                end
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len && sent < n_items; i++)
                begin
                    a = node_t'($urandom);
                    b = ($urandom_range(3) == 0) ? a : node_t'($urandom);
                    send_edge(a, b, $urandom);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        edges_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: index extremes, weight extremes, self loops, a long chain
        send_edge(node_t'(0), LAST_NODE, 32'h8000_0000);
        send_edge(LAST_NODE, node_t'(0), 32'h7FFF_FFFF);
        send_edge(node_t'(5), node_t'(5), 32'h0000_0000);
        send_edge(node_t'(341), node_t'(682), 32'hFFFF_FFFF);
        send_edge(node_t'(0), node_t'(341), 32'd1);
        send_edge(LAST_NODE, node_t'(682), 32'd2);
        for (int k = 20; k < 32; k++)
            send_edge(node_t'(k + 1), node_t'(k), 32'(100 + k));
        send_edge(node_t'(20), node_t'(40), 32'd200);
        send_edge(node_t'(25), node_t'(20), 32'd201);
        send_edge(node_t'(40), node_t'(40), 32'd202);
        wait_drained(20000);

        // Idle phases: none, sender idle, receiver stalled, both
        run_graphs(150);
        wait_drained(20000);
        send_idle_pct = 71;
        run_graphs(150);
        wait_drained(20000);
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        run_graphs(150);
        wait_drained(20000);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        run_graphs(120);
        wait_drained(20000);

        // Long receiver hold-off while edges keep coming, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 300;
        run_graphs(30);
        wait_drained(20000);

        // Watch for stray results after the last expected one
        repeat (200) @(posedge clk);

        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        $display("Sent %0d edges, checked %0d results (%0d joined, %0d rejected),",
                 edges_sent, checked, joins, checked - joins);
        $display("covering chains, clusters, self loops and stalls on both sides.");
        if (fail_count == 0 && pending == 0)
            $display("spanning_forest_edge_filter_core: match");
        else
            $display("spanning_forest_edge_filter_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
